### hw/rtl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, character codes and helper functions for the infix-to-postfix
// converter (controller and datapath).
// ----------------------------------------------------------------------------
package i2p_pkg;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    // Output word source select
    typedef logic [1:0] t_emit_sel;
    localparam t_emit_sel SEL_SYM  = 2'd0;  // incoming character
    localparam t_emit_sel SEL_TOP  = 2'd1;  // top of operator stack
    localparam t_emit_sel SEL_MARK = 2'd2;  // bare end marker

    // Controller -> datapath commands
    typedef struct packed {
        logic      load_in;
        logic      push;
        logic      pop;
        logic      emit;
        t_emit_sel emit_sel;
        logic      emit_last;
        logic      clr_ovf;
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic is_end;
        logic is_alnum;
        logic is_open;
        logic is_close;
        logic cnt_zero;
        logic cnt_one;
        logic top_is_open;
        logic pop_ok;
        logic out_free;
    } t_sts;

    // Operator priority: 0 for anything that is not an arithmetic operator
    function automatic logic [1:0] f_prio(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
        if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
        if (c == CH_CARET)                 p = 2'd3;
        return p;
    endfunction

    function automatic logic f_is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

### hw/rtl/i2p_datapath.sv
// ----------------------------------------------------------------------------
// i2p_datapath
// Input holding register, operator stack memory with registered top read,
// stack count, sticky overflow flag and the output word register.
// ----------------------------------------------------------------------------
module i2p_datapath #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  i2p_pkg::t_cmd i_cmd,
    output i2p_pkg::t_sts o_sts,
    input  logic [7:0]    i_s_tdata,   // [7:0] symbol
    input  logic          i_s_tlast,   // end_of_expression
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [7:0]    o_m_tdata,   // [7:0] out_symbol
    output logic [1:0]    o_m_tuser,   // [0] symbol_valid, [1] overflow
    output logic          o_m_tlast    // last
);
    import i2p_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    logic [7:0]    r_sym;
    logic          r_end;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf;
    logic [7:0]    r_top;
    logic [7:0]    r_mem [STACK_DEPTH];
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] rd_addr;
    logic          full;
    logic          r_m_valid;
    logic [7:0]    r_m_data;
    logic [1:0]    r_m_user;
    logic          r_m_last;

    assign cnt_m1  = r_count - 1'b1;
    assign rd_addr = cnt_m1[AW-1:0];
    assign full    = (r_count == DEPTH_C);

    // Input word holding register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sym <= i_s_tdata;
            r_end <= i_s_tlast;
        end
    end

    // Stack memory: write on push when not full, top read registered every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_mem[r_count[AW-1:0]] <= r_sym;
        end
        r_top <= r_mem[rd_addr];
    end

    // Stack count
    always_comb begin
        n_count = r_count;
        if (i_cmd.pop) begin
            n_count = cnt_m1;
        end else if (i_cmd.push && !full) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.clr_ovf) begin
                r_ovf <= 1'b0;
            end else if (i_cmd.push && full) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (i_cmd.emit_sel)
                SEL_SYM:  r_m_data <= r_sym;
                SEL_TOP:  r_m_data <= r_top;
                default:  r_m_data <= 8'd0;
            endcase
            r_m_user[0] <= (i_cmd.emit_sel != SEL_MARK);
            r_m_user[1] <= i_cmd.emit_last & r_ovf;
            r_m_last    <= i_cmd.emit_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

    // Status to controller
    assign o_sts.is_end      = r_end;
    assign o_sts.is_alnum    = f_is_alnum(r_sym);
    assign o_sts.is_open     = (r_sym == CH_OPEN);
    assign o_sts.is_close    = (r_sym == CH_CLOSE);
    assign o_sts.cnt_zero    = (r_count == '0);
    assign o_sts.cnt_one     = (r_count == CW'(1));
    assign o_sts.top_is_open = (r_top == CH_OPEN);
    assign o_sts.pop_ok      = (f_prio(r_top) >= f_prio(r_sym));
    assign o_sts.out_free    = !r_m_valid || i_m_tready;

endmodule

### hw/rtl/i2p_ctrl.sv
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer: accepts one word, then decides per cycle whether to emit, push
// or pop, with a wait state after each emitting pop but the last of a flush.
// ----------------------------------------------------------------------------
module i2p_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  i2p_pkg::t_sts i_sts,
    output i2p_pkg::t_cmd o_cmd
);
    import i2p_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.is_end) begin
                    // flush: pop everything, last word carries the flag
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        if (i_sts.cnt_zero) begin
                            o_cmd.emit_sel  = SEL_MARK;
                            o_cmd.emit_last = 1'b1;
                            o_cmd.clr_ovf   = 1'b1;
                            n_state         = ST_IDLE;
                        end else begin
                            o_cmd.emit_sel  = SEL_TOP;
                            o_cmd.pop       = 1'b1;
                            o_cmd.emit_last = i_sts.cnt_one;
                            o_cmd.clr_ovf   = i_sts.cnt_one;
                            n_state         = i_sts.cnt_one ? ST_IDLE : ST_WAIT;
                        end
                    end
                end else if (i_sts.is_alnum) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = SEL_SYM;
                        n_state        = ST_IDLE;
                    end
                end else if (i_sts.is_open) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end else if (i_sts.is_close) begin
                    // pop down to the open bracket, then drop it
                    if (i_sts.cnt_zero) begin
                        n_state = ST_IDLE;
                    end else if (i_sts.top_is_open) begin
                        o_cmd.pop = 1'b1;
                        n_state   = ST_IDLE;
                    end else if (i_sts.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = SEL_TOP;
                        o_cmd.pop      = 1'b1;
                        n_state        = ST_WAIT;
                    end
                end else begin
                    // operator or other code: pop higher or equal priority, then push
                    if (!i_sts.cnt_zero && i_sts.pop_ok) begin
                        if (i_sts.out_free) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_sel = SEL_TOP;
                            o_cmd.pop      = 1'b1;
                            n_state        = ST_WAIT;
                        end
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
            end
            ST_WAIT: begin
                // new top of stack is being read
                n_state = ST_EVAL;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard infix-to-postfix converter with an operator stack in memory.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one ASCII character per word in s_tdata; s_tlast
//   marks the end word, which flushes the stack (its data is ignored).
//   Master channel returns postfix characters in m_tdata; m_tuser[0] is set
//   when a character is carried (clear on a bare end marker), m_tuser[1]
//   reports a dropped push on the last word, m_tlast marks the last word.
//   Timing: a word passes an accept state and a decide state before the
//   next can be accepted; a letter or digit is written to the output
//   register from the decide state. Each pop that emits a word, but the
//   last of the end flush, is followed by a wait state for the registered
//   read of the stack memory (one read port) before the next decision.
//   The output register separates the channels: the block keeps working
//   until it needs to emit while the previous word is still stalled, and
//   then waits for m_tready.
//   Reset empties the stack, clears the overflow flag and the output valid.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] symbol
    input  logic       i_s_tlast,   // end_of_expression
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_symbol
    output logic [1:0] o_m_tuser,   // [0] symbol_valid, [1] overflow
    output logic       o_m_tlast    // last
);
    import i2p_pkg::*;

    t_cmd cmd;
    t_sts sts;

    i2p_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    i2p_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Assertions
    a_no_emit_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && cmd.emit))
        else $error("emit while accepting input");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop in the same cycle");

    a_last_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_last |-> sts.is_end)
        else $error("last word outside end flush");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("emit into a full output register");

endmodule

### tb/sv/tb_infix_to_postfix_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter_unit
// Self-checking bench for the stream infix-to-postfix converter. A queue of
// characters (directed corner cases, then random expressions, broken runs,
// noise and stack-filling runs) feeds a clocked driver; a shunting-yard
// predictor tracks the operator stack for every accepted word and a clocked
// monitor checks each output word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter_unit;
    import i2p_pkg::*;

    localparam int DEPTH       = 64;
    localparam int ITEM_TARGET = 470;
    localparam int IDLE_LIMIT  = 4000;   // cycles with no word moving on either side
    localparam int HOLD_AT     = 150;    // input words accepted before the long stall
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_LO     = 250;    // no idling on either side in this window
    localparam int CALM_HI     = 330;
    localparam int DRAIN_AT    = 300;    // queue length; the first word added past it is sent after a drain
    localparam int TAIL_CYCLES = 300;

    typedef struct {
        logic [7:0] sym;
        logic       eoe;
        logic       drain_first;
    } t_infix_word;

    typedef struct {
        logic [7:0] sym;
        logic       has_sym;
        logic       last;
        logic       ovf;
    } t_postfix_word;

    // DUT signals
    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    t_infix_word   pending_words[$];
    t_postfix_word postfix_q[$];
    t_infix_word   bus_word;
    int            words_left  = 0;
    int            accepted_in = 0;
    int            errors      = 0;
    logic          next_drain  = 1'b0;

    // Predictor state
    logic [7:0] op_stack[DEPTH];
    int         stack_fill = 0;
    logic       ovf_sticky = 1'b0;

    always #6 clk = ~clk;

    infix_to_postfix_converter_unit #(
        .STACK_DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // [7:0] symbol
        .i_s_tlast  (s_tlast),    // end_of_expression
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // [7:0] out_symbol
        .o_m_tuser  (m_tuser),    // [0] symbol_valid, [1] overflow
        .o_m_tlast  (m_tlast)     // last
    );

    // ------------------------------------------------------------------------
    // Shunting-yard predictor
    // ------------------------------------------------------------------------
    function automatic int op_rank(input logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS) return 1;
        if (c == CH_STAR || c == CH_SLASH) return 2;
        if (c == CH_CARET) return 3;
        return 0;
    endfunction

    function automatic logic char_is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z");
    endfunction

    task automatic note_postfix(input logic [7:0] sym, input logic has_sym,
                                input logic last, input logic ovf);
        t_postfix_word w;
        w.sym     = sym;
        w.has_sym = has_sym;
        w.last    = last;
        w.ovf     = ovf;
        postfix_q.push_back(w);
    endtask

    task automatic push_op(input logic [7:0] c);
        if (stack_fill >= DEPTH) begin
            ovf_sticky = 1'b1;
        end else begin
            op_stack[stack_fill] = c;
            stack_fill++;
        end
    endtask

    task automatic predict_postfix(input t_infix_word w);
        int rank;
        if (w.eoe) begin
            // flush; the bottom entry (or a bare marker) carries last and overflow
            if (stack_fill == 0) begin
                note_postfix(8'h00, 1'b0, 1'b1, ovf_sticky);
            end else begin
                while (stack_fill > 0) begin
                    stack_fill--;
                    if (stack_fill == 0)
                        note_postfix(op_stack[0], 1'b1, 1'b1, ovf_sticky);
                    else
                        note_postfix(op_stack[stack_fill], 1'b1, 1'b0, 1'b0);
                end
            end
            ovf_sticky = 1'b0;
        end else if (char_is_alnum(w.sym)) begin
            note_postfix(w.sym, 1'b1, 1'b0, 1'b0);
        end else if (w.sym == CH_OPEN) begin
            push_op(w.sym);
        end else if (w.sym == CH_CLOSE) begin
            // pop down to '(' and drop it; an empty stack just stops the pops
            while (stack_fill > 0 && op_stack[stack_fill - 1] != CH_OPEN) begin
                note_postfix(op_stack[stack_fill - 1], 1'b1, 1'b0, 1'b0);
                stack_fill--;
            end
            if (stack_fill > 0) stack_fill--;
        end else begin
            rank = op_rank(w.sym);
            while (stack_fill > 0 && op_rank(op_stack[stack_fill - 1]) >= rank) begin
                note_postfix(op_stack[stack_fill - 1], 1'b1, 1'b0, 1'b0);
                stack_fill--;
            end
            push_op(w.sym);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic add_word(input logic [7:0] sym, input logic eoe);
        t_infix_word w;
        w.sym         = sym;
        w.eoe         = eoe;
        w.drain_first = next_drain;
        next_drain    = 1'b0;
        pending_words.push_back(w);
    endtask

    function automatic logic [7:0] rand_operand();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return 8'("0" + r);
        if (r < 36) return 8'("A" + r - 10);
        return 8'("a" + r - 36);
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 4))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            3: return CH_SLASH;
            default: return CH_CARET;
        endcase
    endfunction

    // well-formed expression with nested brackets
    task automatic gen_expr(input int lvl);
        int terms;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++) begin
            if (t > 0) add_word(rand_operator(), 1'b0);
            if (lvl < 3 && $urandom_range(0, 3) == 0) begin
                add_word(CH_OPEN, 1'b0);
                gen_expr(lvl + 1);
                add_word(CH_CLOSE, 1'b0);
            end else begin
                add_word(rand_operand(), 1'b0);
            end
        end
    endtask

    // '(' and '^' alternate so nothing is popped: 60 to 70 pushes, near or past full
    task automatic gen_deep();
        int n;
        n = $urandom_range(60, 70);
        for (int i = 0; i < n; i++)
            add_word((i % 2) ? CH_CARET : CH_OPEN, 1'b0);
        if ($urandom_range(0, 1)) add_word(CH_CLOSE, 1'b0);
        add_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // unbalanced run drawn from operands, operators and brackets
    task automatic gen_broken();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: add_word(rand_operand(), 1'b0);
                1: add_word(rand_operator(), 1'b0);
                2: add_word(CH_OPEN, 1'b0);
                default: add_word(CH_CLOSE, 1'b0);
            endcase
        end
        if ($urandom_range(0, 1)) add_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            add_word(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
    endtask

    // ------------------------------------------------------------------------
    // Driver: one word on the slave side, held until accepted
    // ------------------------------------------------------------------------
    logic drv_idle;
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_postfix(bus_word);
                accepted_in++;
                words_left--;
            end
            if (!(s_tvalid && !s_tready)) begin
                drv_idle = (accepted_in < CALM_LO || accepted_in >= CALM_HI) &&
                           ($urandom_range(0, 99) < 15);
                if (pending_words.size() != 0 && !drv_idle &&
                    !(pending_words[0].drain_first && postfix_q.size() != 0)) begin
                    bus_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= bus_word.sym;
                    s_tlast  <= bus_word.eoe;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check every accepted output word, drive backpressure
    // ------------------------------------------------------------------------
    t_postfix_word want;
    int            hold_left = 0;
    logic          hold_done = 1'b0;

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (postfix_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, %s %02h user %b last %b",
                             $time, "actual data", m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = postfix_q.pop_front();
                    compare_field("out_symbol", want.sym, m_tdata);
                    compare_field("symbol_valid", want.has_sym, m_tuser[0]);
                    compare_field("overflow", want.ovf, m_tuser[1]);
                    compare_field("last", want.last, m_tlast);
                end
            end
            // one long stall so the input side backs up
            if (!hold_done && accepted_in >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (accepted_in >= CALM_LO && accepted_in < CALM_HI) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: no word moving for too long
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (rst_n) begin
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic deep_done;
        logic drain_set;
        int   pick;
        deep_done = 1'b0;
        drain_set = 1'b0;

        // directed: precedence, brackets, stray closes, priority-zero codes, ends
        add_word("a", 1'b0);
        add_word(CH_PLUS, 1'b0);
        add_word("b", 1'b0);
        add_word(CH_STAR, 1'b0);
        add_word("9", 1'b0);
        add_word(CH_CARET, 1'b0);
        add_word("Z", 1'b0);
        add_word(CH_MINUS, 1'b0);       // pops ^ * +
        add_word(CH_OPEN, 1'b0);
        add_word("x", 1'b0);
        add_word(CH_SLASH, 1'b0);
        add_word("y", 1'b0);
        add_word(CH_CLOSE, 1'b0);
        add_word(CH_CLOSE, 1'b0);       // no '(' left: pops to empty
        add_word(CH_CLOSE, 1'b0);       // empty stack
        add_word("#", 1'b0);            // priority zero
        add_word(CH_OPEN, 1'b0);
        add_word(8'hFF, 1'b0);          // pops '(' and '#'
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b1);          // symbol ignored on end
        add_word(8'h00, 1'b1);          // end on empty stack: bare marker
        add_word("0", 1'b0);
        add_word("A", 1'b0);
        add_word("z", 1'b0);
        add_word(8'h55, 1'b1);

        // random part, mostly well-formed expressions
        while (pending_words.size() < ITEM_TARGET) begin
            // the next word waits until every expected result has come
            if (!drain_set && pending_words.size() >= DRAIN_AT) begin
                next_drain = 1'b1;
                drain_set  = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (!deep_done && pending_words.size() >= 60) begin
                gen_deep();
                deep_done = 1'b1;
            end else if (pick < 3) begin
                gen_deep();
            end else if (pick < 78) begin
                gen_expr(0);
                add_word(8'($urandom_range(0, 255)), 1'b1);
            end else if (pick < 90) begin
                gen_broken();
            end else begin
                gen_noise();
            end
        end
        add_word(8'($urandom_range(0, 255)), 1'b1);
        words_left = pending_words.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (words_left != 0) @(posedge clk);
        while (postfix_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/i2p_pkg.sv
hw/rtl/i2p_datapath.sv
hw/rtl/i2p_ctrl.sv
hw/rtl/infix_to_postfix_converter_unit.sv
tb/sv/tb_infix_to_postfix_converter_unit.sv
